### rtl/core/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared constants and types of the line point generator: coordinate widths,
// controller states and the command and status words between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

   localparam int COORD_W          = 6;
   localparam int COORD_BITS_DEF   = 6;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

endpackage

`default_nettype wire

### rtl/core/lpg_if.sv
// ----------------------------------------------------------------------------
// lpg_req_if / lpg_rsp_if
// Valid/ready channels of the line point generator: one line per request
// word, one pixel per response word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpg_req_if;
   logic                         valid;
   logic                         ready;
   logic [lpg_pkg::COORD_W-1:0]  start_x;
   logic [lpg_pkg::COORD_W-1:0]  start_y;
   logic [lpg_pkg::COORD_W-1:0]  end_x;
   logic [lpg_pkg::COORD_W-1:0]  end_y;

   modport source (output valid, output start_x, output start_y, output end_x,
                   output end_y, input ready);
   modport sink   (input valid, input start_x, input start_y, input end_x,
                   input end_y, output ready);
endinterface

interface lpg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lpg_pkg::COORD_W-1:0]  point_x;
   logic [lpg_pkg::COORD_W-1:0]  point_y;
   logic                         last_point;

   modport source (output valid, output point_x, output point_y,
                   output last_point, input ready);
   modport sink   (input valid, input point_x, input point_y,
                   input last_point, output ready);
endinterface

`default_nettype wire

### rtl/core/line_point_generator_top.sv
// Line point generator. Each request word is one line (start and end grid
// point); the block answers with every pixel from start to end in Bresenham
// order, one response word per pixel, with last_point set on the end point.
// A line of N pixels (N = max(|dx|,|dy|)+1, at most 2^COORD_BITS) is taken
// and folded into the first octant, then walked from the single error and
// position register set at one pixel per cycle while the response side does
// not stall. A new line is taken only after the end point has left.
// Coordinate bits above COORD_BITS are ignored.
// ----------------------------------------------------------------------------
// line_point_generator_top
// Top level: controller plus datapath on valid/ready request and response
// channels.
// ----------------------------------------------------------------------------
`default_nettype none

module line_point_generator_top #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lpg_req_if.sink    req_chan,
   lpg_rsp_if.source  rsp_chan
);
   import lpg_pkg::*;

   cmd_type    cmd;
   status_type status;

   lpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lpg_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock   (clock),
      .cmd     (cmd),
      .start_x (req_chan.start_x),
      .start_y (req_chan.start_y),
      .end_x   (req_chan.end_x),
      .end_y   (req_chan.end_y),
      .status  (status),
      .point_x (rsp_chan.point_x),
      .point_y (rsp_chan.point_y)
   );

   assign rsp_chan.last_point = status.last;

endmodule

`default_nettype wire

### rtl/core/lpg_ctrl.sv
// ----------------------------------------------------------------------------
// lpg_ctrl
// Controller: takes a line, then walks it one pixel per accepted response
// word until the end point has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire lpg_pkg::status_type  status,
   output      lpg_pkg::cmd_type     cmd
);
   import lpg_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (rsp_ready && status.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_WALK: begin
            rsp_valid = 1'b1;
            cmd.step  = rsp_ready && !status.last;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/lpg_datapath.sv
// ----------------------------------------------------------------------------
// lpg_datapath
// Octant fold, Bresenham error register and position counters. Load sets up
// a line; step advances to the next pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_datapath #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire lpg_pkg::cmd_type              cmd,
   input  wire logic [lpg_pkg::COORD_W-1:0]   start_x,
   input  wire logic [lpg_pkg::COORD_W-1:0]   start_y,
   input  wire logic [lpg_pkg::COORD_W-1:0]   end_x,
   input  wire logic [lpg_pkg::COORD_W-1:0]   end_y,
   output      lpg_pkg::status_type           status,
   output      logic [lpg_pkg::COORD_W-1:0]   point_x,
   output      logic [lpg_pkg::COORD_W-1:0]   point_y
);
   import lpg_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int ERR_W = COORD_BITS + 2;

   logic [CB-1:0]          sx, sy, ex, ey;
   logic signed [CB:0]     dx, dy;
   logic [CB:0]            ndx, ndy;
   logic [CB-1:0]          adx, ady;
   logic                   ymaj;
   logic [CB-1:0]          amaj, amin;
   logic signed [ERR_W-1:0] err_init;

   logic                   ymaj_ff;
   logic                   maj_neg_ff, min_neg_ff;
   logic [CB-1:0]          amaj_ff, amin_ff;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [CB-1:0]          major_ff, major_in;
   logic [CB-1:0]          minor_ff, minor_in;
   logic [CB-1:0]          steps_ff, steps_in;
   logic signed [ERR_W-1:0] inc_diag, inc_straight;
   logic [CB-1:0]          px, py;

   assign sx = start_x[CB-1:0];
   assign sy = start_y[CB-1:0];
   assign ex = end_x[CB-1:0];
   assign ey = end_y[CB-1:0];

   assign dx  = $signed({1'b0, ex}) - $signed({1'b0, sx});
   assign dy  = $signed({1'b0, ey}) - $signed({1'b0, sy});
   assign ndx = -dx;
   assign ndy = -dy;
   assign adx = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
   assign ady = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];

   assign ymaj     = ady > adx;
   assign amaj     = ymaj ? ady : adx;
   assign amin     = ymaj ? adx : ady;
   assign err_init = $signed({1'b0, amin, 1'b0}) - $signed({2'b00, amaj});

   assign inc_diag     = $signed({1'b0, amin_ff, 1'b0}) - $signed({1'b0, amaj_ff, 1'b0});
   assign inc_straight = $signed({1'b0, amin_ff, 1'b0});

   always_comb begin
      err_in   = err_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      steps_in = steps_ff;
      if (cmd.load) begin
         err_in   = err_init;
         major_in = ymaj ? sy : sx;
         minor_in = ymaj ? sx : sy;
         steps_in = amaj;
      end else if (cmd.step) begin
         // diagonal only on a strictly positive error
         if (!err_ff[ERR_W-1] && (err_ff != '0)) begin
            err_in   = err_ff + inc_diag;
            minor_in = min_neg_ff ? minor_ff - CB'(1) : minor_ff + CB'(1);
         end else begin
            err_in   = err_ff + inc_straight;
         end
         major_in = maj_neg_ff ? major_ff - CB'(1) : major_ff + CB'(1);
         steps_in = steps_ff - CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      major_ff <= major_in;
      minor_ff <= minor_in;
      steps_ff <= steps_in;
      if (cmd.load) begin
         ymaj_ff    <= ymaj;
         maj_neg_ff <= ymaj ? dy[CB] : dx[CB];
         min_neg_ff <= ymaj ? dx[CB] : dy[CB];
         amaj_ff    <= amaj;
         amin_ff    <= amin;
      end
   end

   assign px = ymaj_ff ? minor_ff : major_ff;
   assign py = ymaj_ff ? major_ff : minor_ff;

   assign point_x     = COORD_W'(px);
   assign point_y     = COORD_W'(py);
   assign status.last = (steps_ff == '0);

endmodule

`default_nettype wire

### rtl/core/lpg_checker.sv
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks of the line point generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [lpg_pkg::COORD_W-1:0]   point_x,
   input wire logic [lpg_pkg::COORD_W-1:0]   point_y,
   input wire logic                          last_point
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(point_x) && $stable(point_y) && $stable(last_point))
      else $error("response word changed while stalled");

   a_line_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted line produced no first pixel");

   a_one_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("new line accepted while pixels pending");

   a_line_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && last_point |=> !rsp_valid)
      else $error("pixel emitted after end point");

endmodule

bind line_point_generator_top lpg_checker u_lpg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .point_x    (rsp_chan.point_x),
   .point_y    (rsp_chan.point_y),
   .last_point (rsp_chan.last_point)
);

`default_nettype wire

### tb/tb_line_point_generator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_point_generator_top
// Drives lines into the line point generator and checks every pixel word it
// returns against an in-bench Bresenham walk of the same line. Directed lines
// cover zero length, straight, diagonal, zero-error and all eight octants;
// random lines follow with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------

module tb_line_point_generator_top;

   import lpg_pkg::*;

   typedef logic [COORD_W-1:0] coord_t;

   typedef struct {
      coord_t sx;
      coord_t sy;
      coord_t ex;
      coord_t ey;
      bit     drain_first;
   } line_t;

   typedef struct {
      coord_t x;
      coord_t y;
      logic   last;
   } pixel_t;

   localparam int LINE_COUNT  = 400;
   localparam int SETTLE_CYC  = 70;

   logic clock;
   logic reset;

   lpg_req_if req_bus ();
   lpg_rsp_if rsp_bus ();

   line_point_generator_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   line_t  pending_lines[$];
   pixel_t expected_pixels[$];
   line_t  on_bus;

   int lines_queued = 0;
   int lines_sent   = 0;
   int pixels_seen  = 0;
   int drain_pauses = 0;
   int fail_count   = 0;
   int idle_left    = 0;
   int burst_left   = 0;
   int stall_mode   = 0;
   int mode_left    = 0;
   int stall_phase  = 0;

   always #5 clock = ~clock;

   // walk the line exactly as the block does and queue its pixels
   function automatic void rasterize_line(line_t ln);
      int     dx, dy, adx, ady, amaj, amin, smaj, smin;
      int     major, minor, err;
      bit     ymaj;
      pixel_t px;
      dx   = int'(ln.ex) - int'(ln.sx);
      dy   = int'(ln.ey) - int'(ln.sy);
      adx  = (dx < 0) ? -dx : dx;
      ady  = (dy < 0) ? -dy : dy;
      ymaj = (ady > adx);
      amaj = ymaj ? ady : adx;
      amin = ymaj ? adx : ady;
      smaj = ymaj ? ((dy < 0) ? -1 : 1) : ((dx < 0) ? -1 : 1);
      smin = ymaj ? ((dx < 0) ? -1 : 1) : ((dy < 0) ? -1 : 1);
      major = ymaj ? int'(ln.sy) : int'(ln.sx);
      minor = ymaj ? int'(ln.sx) : int'(ln.sy);
      err   = 2 * amin - amaj;
      for (int k = 0; k <= amaj; k++) begin
         px.x    = coord_t'(ymaj ? minor : major);
         px.y    = coord_t'(ymaj ? major : minor);
         px.last = (k == amaj);
         expected_pixels.push_back(px);
         if (err > 0) begin
            err   += 2 * (amin - amaj);
            minor += smin;
         end else begin
            err += 2 * amin;
         end
         major += smaj;
      end
   endfunction

   task automatic add_line(int sx, int sy, int ex, int ey, bit drain);
      line_t ln;
      ln.sx = coord_t'(sx);
      ln.sy = coord_t'(sy);
      ln.ex = coord_t'(ex);
      ln.ey = coord_t'(ey);
      ln.drain_first = drain;
      pending_lines.push_back(ln);
      lines_queued++;
   endtask

   function automatic int near_coord(int c);
      int v;
      v = c + $urandom_range(0, 8) - 4;
      if (v < 0) v = 0;
      if (v > 63) v = 63;
      return v;
   endfunction

   // request side: bursts of lines with random gaps, optional drain before a line
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
         idle_left  = 0;
         burst_left = 0;
      end else begin
         offer = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            rasterize_line(on_bus);
            lines_sent++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (pending_lines.size() > 0 &&
                         !(pending_lines[0].drain_first && expected_pixels.size() != 0)) begin
               on_bus = pending_lines.pop_front();
               if (on_bus.drain_first) drain_pauses++;
               offer = 1'b1;
               req_bus.start_x <= on_bus.sx;
               req_bus.start_y <= on_bus.sy;
               req_bus.end_x   <= on_bus.ex;
               req_bus.end_y   <= on_bus.ey;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  if ($urandom_range(0, 3) == 0) begin
                     burst_left = 40;
                     idle_left  = 0;
                  end else begin
                     burst_left = $urandom_range(1, 8);
                     idle_left  = $urandom_range(1, 40);
                  end
               end
            end
         end
         req_bus.valid <= offer;
      end
   end

   // response side: check each pixel word, stall on a changing pattern
   always @(posedge clock) begin
      pixel_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         mode_left   = 0;
         stall_phase = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
                        rsp_bus.point_x, rsp_bus.point_y, rsp_bus.last_point);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_bus.point_x !== want.x || rsp_bus.point_y !== want.y ||
                   rsp_bus.last_point !== want.last) begin
                  $display("%0t: pixel mismatch expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                           $time, want.x, want.y, want.last,
                           rsp_bus.point_x, rsp_bus.point_y, rsp_bus.last_point);
                  fail_count++;
               end
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         stall_phase++;
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_bus.ready <= ((stall_phase % 4) != 3);
         endcase
      end
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int kind, sx, sy;
      clock           = 1'b0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.end_x   = '0;
      req_bus.end_y   = '0;
      rsp_bus.ready   = 1'b0;

      // zero length, straight, full diagonals, zero error, all octants
      add_line( 0,  0,  0,  0, 0);
      add_line(63, 63, 63, 63, 0);
      add_line( 0,  5, 63,  5, 0);
      add_line(63, 40,  0, 40, 0);
      add_line(17,  0, 17, 63, 0);
      add_line(50, 63, 50,  0, 0);
      add_line( 0,  0, 63, 63, 1);
      add_line(63, 63,  0,  0, 0);
      add_line( 0, 63, 63,  0, 0);
      add_line(63,  0,  0, 63, 0);
      add_line( 0,  0,  4,  2, 0);
      add_line(10, 10, 12, 11, 0);
      add_line(20, 20, 30, 24, 0);
      add_line(20, 20, 24, 30, 0);
      add_line(20, 20, 16, 30, 0);
      add_line(20, 20, 10, 24, 0);
      add_line(20, 20, 10, 16, 0);
      add_line(20, 20, 16, 10, 0);
      add_line(20, 20, 24, 10, 0);
      add_line(20, 20, 30, 16, 0);
      add_line( 0,  0, 63, 17, 0);
      add_line(42, 21, 42, 22, 0);

      for (int i = 0; i < LINE_COUNT; i++) begin
         kind = $urandom_range(0, 9);
         sx   = $urandom_range(0, 63);
         sy   = $urandom_range(0, 63);
         if (kind < 6)
            add_line(sx, sy, $urandom_range(0, 63), $urandom_range(0, 63), (i % 97) == 50);
         else if (kind < 8)
            add_line(sx, sy, near_coord(sx), near_coord(sy), 0);
         else if (kind == 8)
            add_line(sx, sy, ($urandom_range(0, 1) == 1) ? sx : $urandom_range(0, 63),
                     ($urandom_range(0, 1) == 1) ? sy : $urandom_range(0, 63), 0);
         else
            add_line(sx, sy, sx, sy, 0);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (lines_sent != lines_queued) @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (expected_pixels.size() != 0) fail_count++;

      $display("lines sent: %0d, pixel words checked: %0d, drain pauses: %0d",
               lines_sent, pixels_seen, drain_pauses);
      $display("mismatches and stray words: %0d", fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
